### hw/rtl/msb_first_bit_packer_top_assert.svh
// Assertion macros used by the checker of the bit packer.
`ifndef MSB_FIRST_BIT_PACKER_TOP_ASSERT_SVH
`define MSB_FIRST_BIT_PACKER_TOP_ASSERT_SVH

// Checked on every clock edge outside reset.
`define BPK_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BPK_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/bpk_pkg.sv
package bpk_pkg;

  localparam int MaxCodeWidth = 32;
  localparam int ByteW        = 8;
  localparam int ValueW       = 32;
  localparam int WidthW       = 6;
  localparam int CntW         = 3;
  localparam int PendW        = ByteW - 1;
  localparam int MaxBytes     = (MaxCodeWidth + ByteW - 1) / ByteW;
  localparam int WholeW       = $clog2(MaxBytes + 1);
  localparam int CmdDepth     = 2;
  localparam int CmdCntW      = $clog2(CmdDepth + 1);
  localparam int ResDepth     = 4;
  localparam int ResCntW      = $clog2(ResDepth + 1);

  // One classified input item as the sequencer sees it.
  typedef struct packed {
    logic              flush;
    logic [ValueW-1:0] value;
    logic [WholeW-1:0] whole;
    logic [CntW-1:0]   rem;
  } cmd_t;

  // One output beat.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } res_t;

  // Byte k of the code, counted from the least significant end; zero past the top.
  function automatic logic [ByteW-1:0] code_byte(logic [ValueW-1:0] v,
                                                 logic [WholeW-1:0] k);
    logic [ValueW+ByteW-1:0] ext;
    ext = {{ByteW{1'b0}}, v} >> ({k, 3'b000});
    return ext[ByteW-1:0];
  endfunction

  // Mask of the n low bits of a byte.
  function automatic logic [ByteW-1:0] low_mask(logic [CntW-1:0] n);
    logic [ByteW:0] t;
    t = ((ByteW+1)'(1) << n) - (ByteW+1)'(1);
    return t[ByteW-1:0];
  endfunction

endpackage

### hw/rtl/bpk_front.sv
module bpk_front
  import bpk_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [ValueW-1:0] code_value_i,
  input  logic [WidthW-1:0] code_width_i,
  input  logic              flush_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  cmd_t               slot_q [CmdDepth];
  logic [CmdCntW-1:0] cnt_q, cnt_d;
  logic [WidthW-1:0]  sat_width;
  cmd_t               new_cmd;
  logic               do_push, do_pop;

  // Widths above the limit are clipped, then split into whole bytes and a tail.
  always_comb begin
    if (code_width_i > WidthW'(MaxCodeWidth)) begin
      sat_width = WidthW'(MaxCodeWidth);
    end else begin
      sat_width = code_width_i;
    end
    new_cmd.flush = flush_i;
    new_cmd.value = code_value_i;
    new_cmd.whole = WholeW'(sat_width >> 3);
    new_cmd.rem   = sat_width[CntW-1:0];
  end

  assign full_o      = (cnt_q == CmdCntW'(CmdDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slot_q[0];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CmdCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CmdCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Shift queue: the head always sits in slot 0.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CmdDepth; i++) begin
      if (do_pop) begin
        if (do_push && (CmdCntW'(i + 1) == cnt_q)) begin
          slot_q[i] <= new_cmd;
        end else if (i < CmdDepth - 1) begin
          slot_q[i] <= slot_q[(i + 1) % CmdDepth];
        end
      end else if (do_push && (CmdCntW'(i) == cnt_q)) begin
        slot_q[i] <= new_cmd;
      end
    end
  end

endmodule

### hw/rtl/bpk_back.sv
module bpk_back
  import bpk_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  logic [PendW-1:0]       pend_q, pend_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [WholeW-1:0]      k_q, k_d, k_inc;
  logic                   step;
  logic [ByteW-1:0]       cur_byte, rem_bits, aligned;
  logic [CntW:0]          sum;
  logic [PendW+ByteW-1:0] wide, grown;
  logic [2*ByteW-1:0]     align_ext;

  assign step      = cmd_valid_i && !res_full_i;
  assign cur_byte  = code_byte(cmd_i.value, k_q);
  assign rem_bits  = cur_byte & low_mask(cmd_i.rem);
  assign sum       = {1'b0, cnt_q} + {1'b0, cmd_i.rem};
  assign k_inc     = k_q + WholeW'(1);
  // Tail bits moved to the top of a byte, so that they line up like a whole byte.
  assign align_ext = {rem_bits, {ByteW{1'b0}}} >> cmd_i.rem;
  assign aligned   = align_ext[ByteW-1:0];
  assign grown     = ({{ByteW{1'b0}}, pend_q} << cmd_i.rem) | {{PendW{1'b0}}, rem_bits};

  always_comb begin
    pend_d     = pend_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    wide       = '0;
    if (step) begin
      if (cmd_i.flush) begin
        // Pending bits padded with zeros at the low end.
        wide       = {pend_q, {ByteW{1'b0}}} >> cnt_q;
        res_o.data = wide[ByteW-1:0];
        res_o.last = 1'b1;
        res_push_o = (cnt_q != '0);
        pend_d     = '0;
        cnt_d      = '0;
        k_d        = '0;
        cmd_pop_o  = 1'b1;
      end else if (k_q < cmd_i.whole) begin
        // A whole byte always completes exactly one output byte.
        wide       = {pend_q, cur_byte} >> cnt_q;
        res_o.data = wide[ByteW-1:0];
        res_o.last = (k_inc == cmd_i.whole) && !sum[CntW];
        res_push_o = 1'b1;
        pend_d     = PendW'(cur_byte & low_mask(cnt_q));
        if ((k_inc == cmd_i.whole) && (cmd_i.rem == '0)) begin
          k_d       = '0;
          cmd_pop_o = 1'b1;
        end else begin
          k_d = k_inc;
        end
      end else begin
        // Tail of the code; completes a byte only if the count reaches eight.
        wide       = {pend_q, aligned} >> cnt_q;
        res_o.data = wide[ByteW-1:0];
        res_o.last = 1'b1;
        res_push_o = sum[CntW];
        cnt_d      = sum[CntW-1:0];
        if (sum[CntW]) begin
          pend_d = PendW'(rem_bits & low_mask(sum[CntW-1:0]));
        end else begin
          pend_d = grown[PendW-1:0];
        end
        k_d       = '0;
        cmd_pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
      k_q    <= '0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      k_q    <= k_d;
    end
  end

endmodule

### hw/rtl/bpk_resq.sv
module bpk_resq
  import bpk_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  res_t             res_i,
  output logic             full_o,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             last_of_run_o
);

  res_t               slot_q [ResDepth];
  logic [ResCntW-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o        = (cnt_q == ResCntW'(ResDepth));
  assign empty_o       = (cnt_q == '0);
  assign do_push       = push_i && !full_o;
  assign do_pop        = pop_i && !empty_o;
  assign out_byte_o    = slot_q[0].data;
  assign last_of_run_o = slot_q[0].last;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + ResCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - ResCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ResDepth; i++) begin
      if (do_pop) begin
        if (do_push && (ResCntW'(i + 1) == cnt_q)) begin
          slot_q[i] <= res_i;
        end else if (i < ResDepth - 1) begin
          slot_q[i] <= slot_q[(i + 1) % ResDepth];
        end
      end else if (do_push && (ResCntW'(i) == cnt_q)) begin
        slot_q[i] <= res_i;
      end
    end
  end

endmodule

### hw/rtl/msb_first_bit_packer_top.sv
// MSB-first bit packer. Each input beat carries a code of 0 to 32 bits (wider
// widths are clipped to 32) or a flush request. Code bytes are taken from the
// least significant end of code_value_i; every whole byte goes out MSB first,
// followed by the low (width mod 8) bits of the next byte, MSB first. Up to
// seven bits wait between items. Every completed byte leaves as one result beat,
// and last_of_run_o marks the final byte caused by an input beat; an item that
// completes no byte (zero width, or a flush with nothing pending) makes no beat.
// A flush pads the pending bits with zeros at the low end, sends that byte if
// any bits were pending, and clears the pending state. Both sides behave like
// queues: a beat enters when push is high and full is low, and the oldest result
// leaves when pop is high and empty is low. Internally a two-entry command queue
// decouples the input side from a byte sequencer, and a four-entry result queue
// decouples the sequencer from the consumer. The sequencer works through each
// item one whole code byte at a time, then its nonzero tail, and takes a flush
// on its own; it produces at most one byte per cycle and waits while the result
// queue is full. On its way to the output ports an input beat is registered
// first in the command queue and then, as a result, in the result queue.
module msb_first_bit_packer_top
  import bpk_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [ValueW-1:0] code_value_i,
  input  logic [WidthW-1:0] code_width_i,
  input  logic              flush_i,
  output logic              empty,
  input  logic              pop,
  output logic [ByteW-1:0]  out_byte_o,
  output logic              last_of_run_o
);

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  res_t res;
  logic res_push, res_full;

  // Front end: clips the width, splits it into whole bytes and tail, queues it.
  bpk_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .code_value_i (code_value_i),
    .code_width_i (code_width_i),
    .flush_i      (flush_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  // Back end: holds the pending bits and produces at most one byte per step.
  bpk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // Result queue in front of the consumer.
  bpk_resq u_resq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (res_push),
    .res_i         (res),
    .full_o        (res_full),
    .empty_o       (empty),
    .pop_i         (pop),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

### hw/rtl/bpk_checker.sv
`include "msb_first_bit_packer_top_assert.svh"

module bpk_checker
  import bpk_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             push,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input logic [ByteW-1:0] out_byte_o,
  input logic             last_of_run_o
);

  // Reset at an edge: at the next, the result queue is empty and input not full.
  `BPK_ASSERT_ANY(a_reset_clear, (!rst_ni |=> (empty && !full)), "queues not clear in reset")

  // The input queue can only fill up after a beat was taken.
  `BPK_ASSERT_CLK(a_full_needs_push, ($rose(full) |-> $past(push && !full)), "full without a beat")

  // A waiting result that is not taken stays put.
  `BPK_ASSERT_CLK(a_result_holds, ((!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(last_of_run_o))), "waiting result changed")

endmodule

bind msb_first_bit_packer_top bpk_checker u_bpk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .push          (push),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .out_byte_o    (out_byte_o),
  .last_of_run_o (last_of_run_o)
);

### dv/msb_first_bit_packer_top_test.sv
`timescale 1ns / 100ps

// Self-checking bench for the MSB-first bit packer. Stimulus items are queued up
// front, a clocked driver offers them on the push side, and a clocked monitor
// watches both handshakes: every accepted input beat runs through a local
// packing model that queues the bytes it should produce, and every accepted
// output beat is checked against the oldest queued byte.
module msb_first_bit_packer_top_test;
  import bpk_pkg::*;

  // Random gaps and stalls are drawn from 0 to this many cycles.
  localparam int MaxIdle       = 12;
  // The receiver refuses results for this long once, so both queues fill up.
  localparam int HoldOffCycles = 200;
  localparam int HoldOffAt     = 30;
  // A run ends if this many cycles pass without any beat on either side.
  localparam int StallLimit    = 2000;
  // Cycles to watch for stray beats after the last expected byte arrived.
  localparam int DrainCycles   = 32;
  localparam int RandomItems   = 180;
  localparam int MaxReports    = 10;

  typedef struct {
    logic [ValueW-1:0] value;
    logic [WidthW-1:0] width;
    logic              flush;
    int unsigned       gap;    // idle cycles before this item is offered
  } code_item_t;

  typedef struct {
    logic [ByteW-1:0] data;
    logic             last;
  } out_beat_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              push          = 1'b0;
  logic              full;
  logic [ValueW-1:0] code_value_i  = '0;
  logic [WidthW-1:0] code_width_i  = '0;
  logic              flush_i       = 1'b0;
  logic              empty;
  logic              pop           = 1'b0;
  logic [ByteW-1:0]  out_byte_o;
  logic              last_of_run_o;

  code_item_t  code_q[$];   // items still to be offered
  out_beat_t   byte_q[$];   // bytes the packer still owes us
  int unsigned items_total;
  int unsigned items_taken  = 0;
  int unsigned bytes_seen   = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;

  // Packing model state: bits waiting for a full byte, newest in bit 0.
  logic [PendW-1:0] pend_bits = '0;
  logic [CntW-1:0]  pend_cnt  = '0;

  // Driver and receiver bookkeeping.
  int unsigned send_wait  = 0;
  int unsigned pop_wait   = 0;
  bit          hold_done  = 1'b0;

  msb_first_bit_packer_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .code_value_i  (code_value_i),
    .code_width_i  (code_width_i),
    .flush_i       (flush_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Packing model. A code is cut into bytes from its least significant end;
  // each whole byte and then the low (width mod 8) bits of the next byte are
  // shifted into the pending bits, and every time eight bits have gathered the
  // oldest eight leave as one byte. A flush pads whatever is pending with zeros
  // at the low end. The final byte an item produces carries the last flag.
  task automatic pack_code(input code_item_t it);
    out_beat_t        made[$];
    logic [14:0]      acc;
    logic [ByteW-1:0] chunk;
    int unsigned      w;
    int unsigned      whole;
    int unsigned      rem;
    int unsigned      n;
    int unsigned      cnt;
    out_beat_t        b;
    if (it.flush) begin
      if (pend_cnt != 0) begin
        acc    = 15'(pend_bits) << (ByteW - pend_cnt);
        b.data = acc[ByteW-1:0];
        b.last = 1'b0;
        made.push_back(b);
      end
      pend_bits = '0;
      pend_cnt  = '0;
    end else begin
      // Widths beyond the code limit are clipped to it.
      w     = (it.width > MaxCodeWidth) ? MaxCodeWidth : it.width;
      whole = w / ByteW;
      rem   = w % ByteW;
      for (int k = 0; k < whole + ((rem != 0) ? 1 : 0); k++) begin
        n     = (k < whole) ? ByteW : rem;
        chunk = 8'(it.value >> (ByteW * k)) & 8'((9'(1) << n) - 9'(1));
        acc   = (15'(pend_bits) << n) | 15'(chunk);
        cnt   = pend_cnt + n;
        // Fewer than eight bits wait, so one piece completes one byte at most.
        if (cnt >= ByteW) begin
          cnt    = cnt - ByteW;
          b.data = 8'(acc >> cnt);
          b.last = 1'b0;
          made.push_back(b);
        end
        pend_cnt  = CntW'(cnt);
        pend_bits = PendW'(acc & ((15'(1) << cnt) - 15'(1)));
      end
    end
    if (made.size() > 0) made[made.size()-1].last = 1'b1;
    foreach (made[i]) byte_q.push_back(made[i]);
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic add_item(input logic [ValueW-1:0] value, input int unsigned width,
                          input logic flush, input int unsigned gap);
    code_item_t it;
    it.value = value;
    it.width = WidthW'(width);
    it.flush = flush;
    it.gap   = gap;
    code_q.push_back(it);
  endtask

  // Driver. While a beat is offered and the block reports full, push and the
  // payload stay put. Otherwise the item's gap is sat out with push low and the
  // next item goes out. Each branch assigns push exactly once per edge.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (push && full) begin
      push <= 1'b1;
    end else if (send_wait > 0) begin
      send_wait--;
      push <= 1'b0;
    end else if (code_q.size() > 0 && code_q[0].gap > 0) begin
      // Start the gap of the head item; clearing it keeps it from restarting.
      send_wait     = code_q[0].gap - 1;
      code_q[0].gap = 0;
      push <= 1'b0;
    end else if (code_q.size() > 0) begin
      code_item_t it;
      it = code_q.pop_front();
      code_value_i <= it.value;
      code_width_i <= it.width;
      flush_i      <= it.flush;
      push         <= 1'b1;
    end else begin
      push <= 1'b0;
    end
  end

  // Monitor and receiver. Both handshakes are sampled at the edge, so values seen
  // here are the ones the block saw. Input beats feed the model; output beats are
  // checked in order. After each byte the receiver draws a stall (none in some
  // stretches), and once early in the run it refuses results for a long stretch
  // while the driver keeps offering items, which backs the block up to its input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      bit moved;
      code_item_t seen;
      out_beat_t  want;
      moved = 1'b0;
      if (push && !full) begin
        seen.value = code_value_i;
        seen.width = code_width_i;
        seen.flush = flush_i;
        seen.gap   = 0;
        pack_code(seen);
        items_taken++;
        moved = 1'b1;
      end
      if (pop && !empty) begin
        moved = 1'b1;
        bytes_seen++;
        if (byte_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b",
                                    out_byte_o, last_of_run_o));
        end else begin
          want = byte_q.pop_front();
          if (out_byte_o !== want.data)
            report_mismatch($sformatf("byte %0d: out_byte expected %02h, got %02h",
                                      bytes_seen, want.data, out_byte_o));
          if (last_of_run_o !== want.last)
            report_mismatch($sformatf("byte %0d: last_of_run expected %0b, got %0b",
                                      bytes_seen, want.last, last_of_run_o));
        end
        if (!hold_done && bytes_seen >= HoldOffAt) begin
          hold_done = 1'b1;
          pop_wait  = HoldOffCycles;
        end else if ((bytes_seen / 32) % 3 == 1) begin
          // A stretch in which the receiver takes every byte at once.
          pop_wait = 0;
        end else begin
          pop_wait = $urandom_range(0, MaxIdle);
        end
      end else if (pop_wait > 0) begin
        pop_wait--;
      end
      pop <= (pop_wait == 0);
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog: nothing moving for too long means the block is stuck or an
  // expected byte never comes.
  initial begin
    while (idle_cycles < StallLimit) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned counted;
    int unsigned sel;
    int unsigned width;
    int unsigned run_len;
    logic [ValueW-1:0] value;

    // Directed part: empty flush and zero width (no byte), full-width codes of
    // all ones and all zeros, a lone bit flushed out, widths clipped to the
    // code limit, pending bits completed by the next code, a flush whose code
    // fields carry junk, high value bits that must be masked off, and a full
    // pending register followed by a full-width code.
    add_item('1, 0, 1'b1, $urandom_range(0, MaxIdle));
    add_item('1, 0, 1'b0, $urandom_range(0, MaxIdle));
    add_item('1, 32, 1'b0, $urandom_range(0, MaxIdle));
    add_item('0, 32, 1'b0, $urandom_range(0, MaxIdle));
    add_item(32'h1, 1, 1'b0, $urandom_range(0, MaxIdle));
    add_item('0, 0, 1'b1, $urandom_range(0, MaxIdle));
    add_item(32'h1234_5678, 63, 1'b0, $urandom_range(0, MaxIdle));
    add_item(32'hA5A5_A5A5, 33, 1'b0, $urandom_range(0, MaxIdle));
    add_item(32'h7F, 7, 1'b0, $urandom_range(0, MaxIdle));
    add_item(32'h0, 1, 1'b0, $urandom_range(0, MaxIdle));
    add_item(32'h5, 3, 1'b0, $urandom_range(0, MaxIdle));
    add_item('1, 32, 1'b1, $urandom_range(0, MaxIdle));
    add_item(32'hABC, 12, 1'b0, $urandom_range(0, MaxIdle));
    add_item(32'h5, 4, 1'b0, $urandom_range(0, MaxIdle));
    add_item(32'h80, 8, 1'b0, 0);
    add_item(32'h01, 8, 1'b0, 0);
    add_item(32'h55, 7, 1'b0, 0);
    add_item(32'hDEAD_BEEF, 32, 1'b0, 0);
    add_item(32'h1, 1, 1'b0, $urandom_range(0, MaxIdle));
    add_item(32'hFFFF_FFFC, 2, 1'b0, $urandom_range(0, MaxIdle));
    add_item(32'h1F, 5, 1'b0, $urandom_range(0, MaxIdle));
    add_item('0, 63, 1'b1, $urandom_range(0, MaxIdle));
    add_item('0, 0, 1'b1, $urandom_range(0, MaxIdle));

    // Random part: runs of codes that usually end in a flush. Zero-width codes
    // are sent too but not counted, since the block does nothing with them.
    counted = 0;
    while (counted < RandomItems) begin
      run_len = $urandom_range(1, 8);
      for (int i = 0; i < run_len; i++) begin
        sel = $urandom_range(0, 9);
        if (sel == 0)      width = $urandom_range(MaxCodeWidth + 1, 63);
        else if (sel == 1) width = 0;
        else if (sel < 5)  width = $urandom_range(1, 8);
        else               width = $urandom_range(1, MaxCodeWidth);
        sel = $urandom_range(0, 9);
        if (sel == 0)      value = '0;
        else if (sel == 1) value = '1;
        else               value = $urandom();
        add_item(value, width, 1'b0,
                 ((counted / 30) % 3 == 1) ? 0 : $urandom_range(0, MaxIdle));
        if (width != 0) counted++;
      end
      if ($urandom_range(0, 9) < 7) begin
        add_item($urandom(), $urandom_range(0, 63), 1'b1, $urandom_range(0, MaxIdle));
        counted++;
      end
    end
    items_total = code_q.size();

    // Hold reset, then release it away from the rising edge.
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (items_taken < items_total) @(posedge clk_i);
    while (byte_q.size() > 0) @(posedge clk_i);
    // Codes that complete no byte may still be in flight; keep watching for
    // stray beats a while longer.
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
